[hw/rtl/lrupfd_pkg.sv]
// shared constants and types for the lru page frame directory
// default geometry, fixed port widths and the control state encoding
`default_nettype none

package lrupfd_pkg;

	// default geometry of the directory
	localparam int LRUPFD_PAGE_SLOTS   = 8;
	localparam int LRUPFD_PAGE_BYTES   = 4096;
	localparam int LRUPFD_ADDRESS_BITS = 32;

	// fixed widths of the beat fields
	localparam int ADDR_W      = 32;
	localparam int SLOT_W      = 3;
	localparam int OFFSET_W    = 12;
	localparam int PAGE_ADDR_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} lrupfd_state_t;

endpackage

`default_nettype wire

[hw/rtl/lrupfd_cell.sv]
// one page frame cell: page number, dirty flag and recency rank of a slot
// passes the running lookup result to its neighbor each cycle; uses lrupfd_pkg
`default_nettype none

module lrupfd_cell
	import lrupfd_pkg::*;
#(
	parameter int PAGE_SLOTS = LRUPFD_PAGE_SLOTS,
	parameter int PN_W       = LRUPFD_ADDRESS_BITS - 12,
	parameter int INDEX      = 0,
	localparam int SW        = $clog2(PAGE_SLOTS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [PN_W-1:0] pnum,
	// running result from the previous cell
	input  wire logic            c_hit,
	input  wire logic [SW-1:0]   c_best_rank,
	input  wire logic [SW-1:0]   c_best_slot,
	input  wire logic [SW-1:0]   c_worst_rank,
	input  wire logic [SW-1:0]   c_worst_slot,
	input  wire logic [PN_W-1:0] c_worst_page,
	input  wire logic            c_worst_dirty,
	// running result towards the next cell
	output logic                 n_hit,
	output logic [SW-1:0]        n_best_rank,
	output logic [SW-1:0]        n_best_slot,
	output logic [SW-1:0]        n_worst_rank,
	output logic [SW-1:0]        n_worst_slot,
	output logic [PN_W-1:0]      n_worst_page,
	output logic                 n_worst_dirty,
	// update broadcast
	input  wire logic            commit_en,
	input  wire logic [SW-1:0]   commit_slot,
	input  wire logic [SW-1:0]   commit_rank,
	input  wire logic            commit_hit,
	input  wire logic            commit_write,
	output logic                 is_mru
);

	logic [PN_W-1:0] page_q;
	logic            dirty_q;
	logic [SW-1:0]   rank_q;
	logic            take_hit;
	logic            take_worst;
	logic            selected;

	assign take_hit   = (page_q == pnum) && (!c_hit || (rank_q < c_best_rank));
	assign take_worst = (rank_q >= c_worst_rank);
	assign selected   = (commit_slot == SW'(INDEX));
	assign is_mru     = (rank_q == '0);

	always_ff @(posedge clk) begin
		n_hit         <= c_hit | take_hit;
		n_best_rank   <= take_hit ? rank_q : c_best_rank;
		n_best_slot   <= take_hit ? SW'(INDEX) : c_best_slot;
		n_worst_rank  <= take_worst ? rank_q : c_worst_rank;
		n_worst_slot  <= take_worst ? SW'(INDEX) : c_worst_slot;
		n_worst_page  <= take_worst ? page_q : c_worst_page;
		n_worst_dirty <= take_worst ? dirty_q : c_worst_dirty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= PN_W'(INDEX);
			dirty_q <= 1'b0;
			rank_q  <= SW'(INDEX);
		end else if (commit_en) begin
			if (selected) begin
				rank_q <= '0;
				if (!commit_hit) begin
					page_q <= pnum;
				end
				// a refill starts clean, a write leaves it dirty
				dirty_q <= commit_write | (commit_hit & dirty_q);
			end else if (rank_q < commit_rank) begin
				rank_q <= rank_q + SW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lru_page_frame_directory_unit.sv]
// Directory of a fully associative page cache with least recently used
// replacement. Each access beat walks a row of PAGE_SLOTS cells, one cell per
// cycle, to find the most recent matching slot and the least recent slot;
// a commit step then updates all cells at once and loads the result register.
// A new access is accepted only after the previous one has been committed.
// The result register lets a new access start while the previous result is
// still stalled; the update waits only while that register holds a stalled result.
// After reset slot i holds page i, is clean and has recency rank i.
// uses lrupfd_pkg and lrupfd_cell
`default_nettype none

module lru_page_frame_directory_unit
	import lrupfd_pkg::*;
#(
	parameter int PAGE_SLOTS   = LRUPFD_PAGE_SLOTS,
	parameter int PAGE_BYTES   = LRUPFD_PAGE_BYTES,
	parameter int ADDRESS_BITS = LRUPFD_ADDRESS_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   req_type,
	input  wire logic [ADDR_W-1:0]      address,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [SLOT_W-1:0]           slot,
	output logic [OFFSET_W-1:0]         page_offset,
	output logic                        hit,
	output logic                        writeback,
	output logic [PAGE_ADDR_W-1:0]      victim_page,
	output logic [PAGE_ADDR_W-1:0]      fill_page
);

	// log2 of the largest power of two not above the page size
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES + 1) - 1;
	localparam int SW         = $clog2(PAGE_SLOTS);
	localparam int PN_BITS    = ADDRESS_BITS - PAGE_SHIFT;
	// page numbers also hold the reset pages 0 .. PAGE_SLOTS-1 without aliasing
	localparam int PN_W       = (PN_BITS > SW) ? PN_BITS : SW;
	localparam int PA_W       = PN_W + PAGE_SHIFT + PAGE_ADDR_W;

	lrupfd_state_t state_q, state_d;
	logic [SW-1:0] cnt_q;

	logic [ADDR_W+63:0]       addr_wide;
	logic [ADDRESS_BITS-1:0]  addr_m;
	logic [PN_W-1:0]          pnum_q;
	logic [PAGE_SHIFT-1:0]    offset_q;
	logic                     write_q;

	logic                     in_fire;
	logic                     out_fire;
	logic                     commit_en;

	// running lookup result between cells, entry 0 is the start value
	logic                     c_hit       [PAGE_SLOTS+1];
	logic [SW-1:0]            c_best_rank [PAGE_SLOTS+1];
	logic [SW-1:0]            c_best_slot [PAGE_SLOTS+1];
	logic [SW-1:0]            c_worst_rank[PAGE_SLOTS+1];
	logic [SW-1:0]            c_worst_slot[PAGE_SLOTS+1];
	logic [PN_W-1:0]          c_worst_page[PAGE_SLOTS+1];
	logic                     c_worst_dirty[PAGE_SLOTS+1];
	logic [PAGE_SLOTS-1:0]    is_mru;

	logic                     f_hit;
	logic [SW-1:0]            f_slot;
	logic [SW-1:0]            f_rank;
	logic                     f_wb;
	logic [SW+SLOT_W-1:0]     slot_wide;
	logic [PAGE_SHIFT+OFFSET_W-1:0] off_wide;
	logic [PA_W-1:0]          victim_wide;
	logic [PA_W-1:0]          fill_wide;

	logic                     out_valid_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [OFFSET_W-1:0]      offset_out_q;
	logic                     hit_q;
	logic                     wb_q;
	logic [PAGE_ADDR_W-1:0]   victim_q;
	logic [PAGE_ADDR_W-1:0]   fill_q;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	// bits above ADDRESS_BITS are dropped
	assign addr_wide = {64'b0, address};
	assign addr_m    = addr_wide[ADDRESS_BITS-1:0];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pnum_q   <= PN_W'(addr_m >> PAGE_SHIFT);
			offset_q <= addr_m[PAGE_SHIFT-1:0];
			write_q  <= req_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + SW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		commit_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// the last cell holds the full result once the walk has passed every cell
				if (cnt_q == SW'(PAGE_SLOTS - 1)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!(out_valid_q && out_stall)) begin
					commit_en = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign c_hit[0]         = 1'b0;
	assign c_best_rank[0]   = '0;
	assign c_best_slot[0]   = '0;
	assign c_worst_rank[0]  = '0;
	assign c_worst_slot[0]  = '0;
	assign c_worst_page[0]  = '0;
	assign c_worst_dirty[0] = 1'b0;

	for (genvar i = 0; i < PAGE_SLOTS; i++) begin : g_cell
		lrupfd_cell #(
			.PAGE_SLOTS (PAGE_SLOTS),
			.PN_W       (PN_W),
			.INDEX      (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.pnum          (pnum_q),
			.c_hit         (c_hit[i]),
			.c_best_rank   (c_best_rank[i]),
			.c_best_slot   (c_best_slot[i]),
			.c_worst_rank  (c_worst_rank[i]),
			.c_worst_slot  (c_worst_slot[i]),
			.c_worst_page  (c_worst_page[i]),
			.c_worst_dirty (c_worst_dirty[i]),
			.n_hit         (c_hit[i+1]),
			.n_best_rank   (c_best_rank[i+1]),
			.n_best_slot   (c_best_slot[i+1]),
			.n_worst_rank  (c_worst_rank[i+1]),
			.n_worst_slot  (c_worst_slot[i+1]),
			.n_worst_page  (c_worst_page[i+1]),
			.n_worst_dirty (c_worst_dirty[i+1]),
			.commit_en     (commit_en),
			.commit_slot   (f_slot),
			.commit_rank   (f_rank),
			.commit_hit    (f_hit),
			.commit_write  (write_q),
			.is_mru        (is_mru[i])
		);
	end

	assign f_hit  = c_hit[PAGE_SLOTS];
	assign f_slot = f_hit ? c_best_slot[PAGE_SLOTS] : c_worst_slot[PAGE_SLOTS];
	assign f_rank = f_hit ? c_best_rank[PAGE_SLOTS] : c_worst_rank[PAGE_SLOTS];
	assign f_wb   = !f_hit && c_worst_dirty[PAGE_SLOTS];

	assign slot_wide   = (SW + SLOT_W)'(f_slot);
	assign off_wide    = (PAGE_SHIFT + OFFSET_W)'(offset_q);
	assign victim_wide = PA_W'(c_worst_page[PAGE_SLOTS]) << PAGE_SHIFT;
	assign fill_wide   = PA_W'(pnum_q) << PAGE_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			slot_q       <= slot_wide[SLOT_W-1:0];
			offset_out_q <= off_wide[OFFSET_W-1:0];
			hit_q        <= f_hit;
			wb_q         <= f_wb;
			victim_q     <= f_wb ? victim_wide[PAGE_ADDR_W-1:0] : '0;
			fill_q       <= f_hit ? '0 : fill_wide[PAGE_ADDR_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign slot        = slot_q;
	assign page_offset = offset_out_q;
	assign hit         = hit_q;
	assign writeback   = wb_q;
	assign victim_page = victim_q;
	assign fill_page   = fill_q;

	// exactly one slot is most recent at all times
	a_one_mru: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(is_mru))
		else $error("recency ranks lost their single most recent slot");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SCAN))
		else $error("accepted beat did not start a scan");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
		else $error("result appeared without a commit");

	a_hit_no_eviction: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && hit_q) |-> (!wb_q && (fill_q == '0) && (victim_q == '0)))
		else $error("hit result reports an eviction or fill");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		commit_en |-> !(out_valid_q && out_stall))
		else $error("commit overwrote a stalled result");

endmodule

`default_nettype wire
